// ===== hw/rtl/ltps_pkg.sv =====
// ----------------------------------------------------------------------------
// ltps_pkg
// Types, command codes and slot state codes shared by the least-tickets
// process scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ltps_pkg;

   localparam int CMD_W  = 3;
   localparam int SLOT_W = 6;
   localparam int VAL_W  = 16;
   localparam int ST_W   = 3;
   localparam int TK_W   = 16;
   localparam int CNT_W  = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET_STATE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_TICKETS = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PICK        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CHARGE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STATS       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd5;

   // slot lifecycle codes
   localparam logic [ST_W-1:0] ST_UNUSED   = 3'd0;
   localparam logic [ST_W-1:0] ST_EMBRYO   = 3'd1;
   localparam logic [ST_W-1:0] ST_SLEEPING = 3'd2;
   localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd3;
   localparam logic [ST_W-1:0] ST_RUNNING  = 3'd4;
   localparam logic [ST_W-1:0] ST_ZOMBIE   = 3'd5;

   localparam logic [TK_W-1:0] TICKET_LIMIT     = 16'd10000;
   localparam logic [TK_W-1:0] INIT_TICKETS_RST = 16'd10;

   typedef struct packed {
      logic [ST_W-1:0]  state;
      logic [TK_W-1:0]  tickets;
      logic [CNT_W-1:0] sleep_cnt;
      logic [CNT_W-1:0] ready_cnt;
      logic [CNT_W-1:0] run_cnt;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture an accepted transaction
      logic clear_wr;   // zero the entry at the sweep index
      logic scan_rd;    // read the entry at the sweep index
      logic access_rd;  // read the addressed or picked entry
      logic modify;     // update that entry and issue the result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic idx_last;
   } sts_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ltps_ram.sv =====
// ----------------------------------------------------------------------------
// ltps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ltps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ltps_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltps_ctrl
// Sequencer for the scheduler: clearing sweep after reset, slot table scan
// for pick and stats tick, then access and update of one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ltps_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ltps_pkg::CMD_W-1:0]   req_cmd,
   input  wire ltps_pkg::sts_type            sts,
   output ltps_pkg::ctl_type                 ctl,
   output logic                              busy
);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      SCAN,
      DRAIN,
      ACCESS,
      MODIFY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_scan;

   assign req_scan = (req_cmd inside {ltps_pkg::CMD_PICK, ltps_pkg::CMD_STATS});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLEAR: begin
            if (sts.idx_last) state_in = IDLE;
         end
         IDLE: begin
            if (start) state_in = req_scan ? SCAN : ACCESS;
         end
         SCAN: begin
            if (sts.idx_last) state_in = DRAIN;
         end
         DRAIN:  state_in = ACCESS;
         ACCESS: state_in = MODIFY;
         MODIFY: state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctl           = '0;
      ctl.load      = (state_ff == IDLE) && start;
      ctl.clear_wr  = (state_ff == CLEAR);
      ctl.scan_rd   = (state_ff == SCAN);
      ctl.access_rd = (state_ff == ACCESS);
      ctl.modify    = (state_ff == MODIFY);
   end

   assign busy = (state_ff != IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ltps_dp.sv =====
// ----------------------------------------------------------------------------
// ltps_dp
// Datapath: slot table memory, sweep index, scan pipeline for pick and
// stats tick, entry update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ltps_dp #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ltps_pkg::ctl_type            ctl,
   output ltps_pkg::sts_type                 sts,
   input  wire logic [ltps_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [ltps_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [ltps_pkg::VAL_W-1:0]   req_value,
   input  wire logic                         csr_wr_en,
   input  wire logic [ltps_pkg::TK_W-1:0]    csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [ltps_pkg::SLOT_W-1:0]       rsp_chosen_slot,
   output logic [ltps_pkg::ST_W-1:0]         rsp_slot_state,
   output logic [ltps_pkg::TK_W-1:0]         rsp_slot_tickets,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_sleeping_time,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_ready_time,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_running_time
);

   localparam int AW     = $clog2(NUM_SLOTS);
   localparam int SlotW  = ltps_pkg::SLOT_W;
   localparam int ValW   = ltps_pkg::VAL_W;
   localparam int StW    = ltps_pkg::ST_W;
   localparam int TkW    = ltps_pkg::TK_W;
   localparam int CW     = (AW > SlotW) ? AW : SlotW;
   localparam int EntryW = $bits(ltps_pkg::entry_type);

   // transaction capture
   logic [ltps_pkg::CMD_W-1:0] cmd_ff;
   logic [SlotW-1:0]           slot_ff;
   logic [ValW-1:0]            value_ff;
   logic [TkW-1:0]             init_tk_ff;

   // sweep index and scan pipeline
   logic [AW-1:0] idx_ff;
   logic          pipe_vld_ff;
   logic [AW-1:0] pipe_addr_ff;

   // pick tracking
   logic [TkW-1:0] best_tk_ff;
   logic [AW-1:0]  best_idx_ff;
   logic           hit_ff;

   // result registers
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic [SlotW-1:0]             rsp_slot_ff;
   ltps_pkg::entry_type          rsp_entry_ff;

   logic [CW:0]         slot_w;
   logic                slot_ok;
   logic [AW-1:0]       slot_addr;
   logic [AW-1:0]       acc_addr;
   logic                is_pick;
   logic                is_stats;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   ltps_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [EntryW-1:0]   ram_rd_raw;
   ltps_pkg::entry_type rd_e;

   ltps_pkg::entry_type stats_e;
   logic                stats_wr;
   logic                pick_better;

   ltps_pkg::entry_type mod_e;
   logic                mod_wr;
   logic                mod_found;
   logic [SlotW-1:0]    mod_slot;
   logic                mod_zero;
   logic [TkW:0]        charge_sum;

   assign rd_e      = ltps_pkg::entry_type'(ram_rd_raw);
   assign slot_w    = (CW+1)'(slot_ff);
   assign slot_ok   = slot_w < (CW+1)'(NUM_SLOTS);
   assign slot_addr = slot_w[AW-1:0];
   assign is_pick   = (cmd_ff == ltps_pkg::CMD_PICK);
   assign is_stats  = (cmd_ff == ltps_pkg::CMD_STATS);
   assign acc_addr  = is_pick ? best_idx_ff : slot_addr;

   assign sts.idx_last = (idx_ff == AW'(NUM_SLOTS - 1));

   // scan stage: data of the entry read in the previous cycle
   always_comb begin
      stats_e = rd_e;
      case (rd_e.state)
         ltps_pkg::ST_SLEEPING: stats_e.sleep_cnt = ltps_pkg::sat_inc(rd_e.sleep_cnt);
         ltps_pkg::ST_RUNNABLE: stats_e.ready_cnt = ltps_pkg::sat_inc(rd_e.ready_cnt);
         ltps_pkg::ST_RUNNING:  stats_e.run_cnt   = ltps_pkg::sat_inc(rd_e.run_cnt);
         default: ;
      endcase
   end

   assign stats_wr    = pipe_vld_ff && is_stats;
   assign pick_better = pipe_vld_ff && is_pick && (rd_e.state == ltps_pkg::ST_RUNNABLE)
                        && (rd_e.tickets < best_tk_ff);

   // single entry update
   assign charge_sum = {1'b0, rd_e.tickets} + {1'b0, value_ff};

   always_comb begin
      mod_e     = rd_e;
      mod_wr    = 1'b0;
      mod_found = 1'b1;
      mod_slot  = slot_ff;
      mod_zero  = !slot_ok;
      case (cmd_ff)
         ltps_pkg::CMD_PICK: begin
            mod_found   = hit_ff;
            mod_slot    = hit_ff ? SlotW'(best_idx_ff) : '0;
            mod_zero    = !hit_ff;
            mod_wr      = hit_ff;
            mod_e.state = ltps_pkg::ST_RUNNING;
         end
         ltps_pkg::CMD_SET_STATE: begin
            // codes above zombie leave the slot alone
            if (value_ff <= ValW'(ltps_pkg::ST_ZOMBIE)) begin
               mod_wr      = slot_ok;
               mod_e.state = value_ff[StW-1:0];
               if (value_ff[StW-1:0] == ltps_pkg::ST_EMBRYO) begin
                  mod_e.tickets = init_tk_ff;
               end
               if (value_ff[StW-1:0] == ltps_pkg::ST_UNUSED) begin
                  mod_e.sleep_cnt = '0;
                  mod_e.ready_cnt = '0;
                  mod_e.run_cnt   = '0;
               end
            end
         end
         ltps_pkg::CMD_SET_TICKETS: begin
            mod_wr        = slot_ok;
            mod_e.tickets = value_ff;
         end
         ltps_pkg::CMD_CHARGE: begin
            mod_wr        = slot_ok;
            mod_e.tickets = charge_sum[TkW] ? {TkW{1'b1}} : charge_sum[TkW-1:0];
         end
         default: ;
      endcase
   end

   // memory port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = '0;
      if (ctl.clear_wr) begin
         ram_wr_en = 1'b1;
      end else if (stats_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pipe_addr_ff;
         ram_wr_data = stats_e;
      end else if (ctl.modify) begin
         ram_wr_en   = mod_wr;
         ram_wr_addr = acc_addr;
         ram_wr_data = mod_e;
      end
   end

   assign ram_rd_en   = ctl.scan_rd || ctl.access_rd;
   assign ram_rd_addr = ctl.scan_rd ? idx_ff : acc_addr;

   ltps_ram #(
      .WIDTH (EntryW),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         init_tk_ff   <= ltps_pkg::INIT_TICKETS_RST;
         idx_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            init_tk_ff <= csr_wr_data;
         end
         if (ctl.load) begin
            idx_ff <= '0;
         end else if (ctl.clear_wr || ctl.scan_rd) begin
            idx_ff <= idx_ff + 1'b1;
         end
         pipe_vld_ff <= ctl.scan_rd;
         if (ctl.load) begin
            hit_ff <= 1'b0;
         end else if (pick_better) begin
            hit_ff <= 1'b1;
         end
         rsp_valid_ff <= ctl.modify;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff     <= req_cmd;
         slot_ff    <= req_slot;
         value_ff   <= req_value;
         best_tk_ff <= ltps_pkg::TICKET_LIMIT;
      end else if (pick_better) begin
         best_tk_ff  <= rd_e.tickets;
         best_idx_ff <= pipe_addr_ff;
      end
      pipe_addr_ff <= idx_ff;
      if (ctl.modify) begin
         rsp_found_ff <= mod_found;
         rsp_slot_ff  <= mod_slot;
         rsp_entry_ff <= mod_zero ? '0 : mod_e;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_chosen_slot   = rsp_slot_ff;
   assign rsp_slot_state    = rsp_entry_ff.state;
   assign rsp_slot_tickets  = rsp_entry_ff.tickets;
   assign rsp_sleeping_time = rsp_entry_ff.sleep_cnt;
   assign rsp_ready_time    = rsp_entry_ff.ready_cnt;
   assign rsp_running_time  = rsp_entry_ff.run_cnt;

endmodule

`default_nettype wire

// ===== hw/rtl/least_tickets_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// least_tickets_process_scheduler
// Process slot table with least-tickets pick, ticket charging and per-state
// time statistics.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (req_cmd, req_slot, req_value) is taken at a clock
//   edge with start high and busy low. Every transaction gives exactly one
//   result, shown on the rsp_ ports for one cycle with rsp_valid high; the
//   receiver must take it then, it cannot stall the block.
//   Set state, set tickets, charge and read pass, after acceptance, through
//   one slot table read, one update step and one result register, and busy
//   is low again in the result cycle.
//   Pick and stats tick walk the whole slot table through its single read
//   port, one slot a cycle, then drain, read the entry and update it; busy
//   stays high until the result, so back-to-back scans do not overlap.
//   initial_tickets is written through csr_wr_en / csr_wr_data while the
//   block is idle; it resets to 10.
//   After reset a sweep clears all NUM_SLOTS slot table entries, during
//   which busy is high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module least_tickets_process_scheduler #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [ltps_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [ltps_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [ltps_pkg::VAL_W-1:0]   req_value,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [ltps_pkg::SLOT_W-1:0]       rsp_chosen_slot,
   output logic [ltps_pkg::ST_W-1:0]         rsp_slot_state,
   output logic [ltps_pkg::TK_W-1:0]         rsp_slot_tickets,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_sleeping_time,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_ready_time,
   output logic [ltps_pkg::CNT_W-1:0]        rsp_running_time,
   input  wire logic                         csr_wr_en,
   input  wire logic [ltps_pkg::TK_W-1:0]    csr_wr_data
);

   ltps_pkg::ctl_type ctl;
   ltps_pkg::sts_type sts;

   ltps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   ltps_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_value         (req_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_chosen_slot   (rsp_chosen_slot),
      .rsp_slot_state    (rsp_slot_state),
      .rsp_slot_tickets  (rsp_slot_tickets),
      .rsp_sleeping_time (rsp_sleeping_time),
      .rsp_ready_time    (rsp_ready_time),
      .rsp_running_time  (rsp_running_time)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ltps_checker.sv =====
// ----------------------------------------------------------------------------
// ltps_checker
// Port-level checks of the scheduler's command and result timing and values.
// ----------------------------------------------------------------------------
`default_nettype none

module ltps_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_found,
   input wire logic [ltps_pkg::SLOT_W-1:0]  rsp_chosen_slot,
   input wire logic [ltps_pkg::ST_W-1:0]    rsp_slot_state,
   input wire logic [ltps_pkg::TK_W-1:0]    rsp_slot_tickets
);

   // an accepted transaction keeps the block busy until its result
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   // one result per transaction, never in consecutive cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe high in consecutive cycles");

   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the block is busy");

   // an empty pick reports an all-zero slot
   a_empty_pick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_chosen_slot == '0 && rsp_slot_state == ltps_pkg::ST_UNUSED
          && rsp_slot_tickets == '0))
      else $error("empty pick reported a nonzero slot");

   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot_state <= ltps_pkg::ST_ZOMBIE))
      else $error("result carries an undefined lifecycle code");

endmodule

bind least_tickets_process_scheduler ltps_checker u_ltps_checker (.*);

`default_nettype wire
